@@ hw/rtl/fit_pkg.sv @@
// Shared types and constants of the frame interval timer.
package fit_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_START = 2'd2,
    REQ_RESET = 2'd3
  } req_kind_e;

  localparam logic [31:0] TPS_RESET = 32'd10000000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [31:0] avg_frame_ticks;
    logic [31:0] frame_rate;
    logic [63:0] total_ticks;
    logic        is_stopped;
  } res_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic check;
    logic push;
    logic sum_add;
    logic div_go;
    logic pause;
    logic tot1;
    logic tot2;
    logic load_out;
  } fit_cmd_t;

  typedef struct packed {
    logic tick_run;
    logic start_stop;
    logic cnt_zero;
    logic div_done;
  } fit_sts_t;

endpackage

@@ hw/rtl/fit_stream_if.sv @@
// Valid/ready channel carrying one word of type T.
interface fit_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fit_div.sv @@
// Bit-serial restoring divider: window sum over entry count.
module fit_div #(
  parameter int SUM_W = 39,
  parameter int CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quo_o
);
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              ge;

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign ge        = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d  = {quo_q[SUM_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

@@ hw/rtl/fit_dp.sv @@
// Datapath: timestamps, interval window, rate counters and result word.
module fit_dp #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  fit_pkg::req_t    req_i,
  input  fit_pkg::fit_cmd_t cmd_i,
  output fit_pkg::fit_sts_t sts_o,
  output fit_pkg::res_t    res_o
);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = 32 + CNT_W;

  logic [31:0] mem_q [WINDOW_DEPTH];

  logic [1:0]        kind_q;
  logic [63:0]       ts_q;
  logic [31:0]       tps_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [HEAD_W-1:0] head_q;
  logic [SUM_W-1:0]  sum_q;
  logic [31:0]       avg_q;
  logic [31:0]       fc_q;
  logic [32:0]       acc_q;
  logic [31:0]       rate_q;
  logic [63:0]       prev_q, cur_q, base_q, stop_q, paused_q;
  logic              stopped_q;
  logic [31:0]       iv_q;
  logic              push_q;
  logic [31:0]       rd_q;
  logic [63:0]       delta_q, t1_q, total_q;
  fit_pkg::res_t     res_q;

  logic [63:0]       wide;
  logic [31:0]       iv_sat;
  logic [31:0]       diff;
  logic [32:0]       acc_new;
  logic              full;
  logic [HEAD_W-1:0] head_nxt;
  logic              div_done;
  logic [SUM_W-1:0]  quo;

  assign wide     = ts_q - prev_q;
  assign iv_sat   = (|wide[63:32]) ? 32'hFFFF_FFFF : wide[31:0];
  assign diff     = (iv_q >= avg_q) ? (iv_q - avg_q) : (avg_q - iv_q);
  assign acc_new  = acc_q + {1'b0, iv_q};
  assign full     = cnt_q == CNT_W'(WINDOW_DEPTH);
  assign head_nxt = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);

  fit_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go && (cnt_q != '0)),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q     <= fit_pkg::TPS_RESET;
      cnt_q     <= '0;
      head_q    <= '0;
      sum_q     <= '0;
      avg_q     <= '0;
      fc_q      <= '0;
      acc_q     <= '0;
      rate_q    <= '0;
      prev_q    <= '0;
      cur_q     <= '0;
      base_q    <= '0;
      stop_q    <= '0;
      paused_q  <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        unique case (kind_q)
          fit_pkg::REQ_TICK: begin
            if (stopped_q) begin
              avg_q <= '0;
            end else begin
              cur_q  <= ts_q;
              prev_q <= ts_q;
            end
          end
          fit_pkg::REQ_STOP: begin
            if (!stopped_q) begin
              stop_q    <= ts_q;
              stopped_q <= 1'b1;
            end
          end
          fit_pkg::REQ_START: begin
            if (stopped_q) begin
              prev_q    <= ts_q;
              stop_q    <= '0;
              stopped_q <= 1'b0;
            end
          end
          default: begin
            base_q    <= ts_q;
            prev_q    <= ts_q;
            stop_q    <= '0;
            stopped_q <= 1'b0;
          end
        endcase
      end
      if (cmd_i.check) begin
        if (acc_new > {1'b0, tps_q}) begin
          rate_q <= fc_q + 32'd1;
          fc_q   <= '0;
          acc_q  <= '0;
        end else begin
          fc_q  <= fc_q + 32'd1;
          acc_q <= acc_new;
        end
      end
      if (cmd_i.push && push_q) begin
        head_q <= head_nxt;
        if (full) begin
          sum_q <= sum_q - SUM_W'(rd_q);
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.sum_add && push_q) begin
        sum_q <= sum_q + SUM_W'(iv_q);
      end
      if (cmd_i.div_go && (cnt_q == '0)) begin
        avg_q <= '0;
      end
      if (div_done) begin
        avg_q <= quo[31:0];
      end
      if (cmd_i.pause) begin
        paused_q <= paused_q + delta_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_i.req_type;
      ts_q   <= req_i.timestamp;
    end
    if (cmd_i.exec) begin
      iv_q    <= iv_sat;
      delta_q <= ts_q - stop_q;
    end
    if (cmd_i.check) begin
      push_q <= diff < tps_q;
      rd_q   <= mem_q[head_q];
    end
    if (cmd_i.push && push_q) begin
      mem_q[head_q] <= iv_q;
    end
    if (cmd_i.tot1) begin
      t1_q <= (stopped_q ? stop_q : cur_q) - paused_q;
    end
    if (cmd_i.tot2) begin
      total_q <= t1_q - base_q;
    end
    if (cmd_i.load_out) begin
      res_q.avg_frame_ticks <= stopped_q ? '0 : avg_q;
      res_q.frame_rate      <= rate_q;
      res_q.total_ticks     <= total_q;
      res_q.is_stopped      <= stopped_q;
    end
  end

  assign sts_o.tick_run   = (kind_q == fit_pkg::REQ_TICK) && !stopped_q;
  assign sts_o.start_stop = (kind_q == fit_pkg::REQ_START) && stopped_q;
  assign sts_o.cnt_zero   = cnt_q == '0;
  assign sts_o.div_done   = div_done;
  assign res_o            = res_q;
endmodule

@@ hw/rtl/fit_ctrl.sv @@
// Controller: sequences one event through the datapath and owns the handshakes.
module fit_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  input  fit_pkg::fit_sts_t sts_i,
  output fit_pkg::fit_cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_PUSH   = 4'd3;
  localparam logic [3:0] S_SUMADD = 4'd4;
  localparam logic [3:0] S_DIVGO  = 4'd5;
  localparam logic [3:0] S_DIVW   = 4'd6;
  localparam logic [3:0] S_PAUSE  = 4'd7;
  localparam logic [3:0] S_TOT1   = 4'd8;
  localparam logic [3:0] S_TOT2   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       load_out;
  logic       accept;

  assign accept   = (state_q == S_IDLE) && req_valid_i;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || res_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.tick_run) begin
          state_d = S_CHECK;
        end else if (sts_i.start_stop) begin
          state_d = S_PAUSE;
        end else begin
          state_d = S_TOT1;
        end
      end
      S_CHECK:  state_d = S_PUSH;
      S_PUSH:   state_d = S_SUMADD;
      S_SUMADD: state_d = S_DIVGO;
      S_DIVGO:  state_d = sts_i.cnt_zero ? S_TOT1 : S_DIVW;
      S_DIVW:   if (sts_i.div_done) state_d = S_TOT1;
      S_PAUSE:  state_d = S_TOT1;
      S_TOT1:   state_d = S_TOT2;
      S_TOT2:   state_d = S_DONE;
      S_DONE:   if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.capture  = accept;
  assign cmd_o.exec     = state_q == S_EXEC;
  assign cmd_o.check    = state_q == S_CHECK;
  assign cmd_o.push     = state_q == S_PUSH;
  assign cmd_o.sum_add  = state_q == S_SUMADD;
  assign cmd_o.div_go   = state_q == S_DIVGO;
  assign cmd_o.pause    = state_q == S_PAUSE;
  assign cmd_o.tot1     = state_q == S_TOT1;
  assign cmd_o.tot2     = state_q == S_TOT2;
  assign cmd_o.load_out = load_out;

  assign req_ready_o = state_q == S_IDLE;
  assign res_valid_o = out_valid_q;

  // an accepted word always starts its execute step next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted word did not start execution");

  // divider never runs on an empty window
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVW |-> !sts_i.cnt_zero)
    else $error("divide with empty window");

  // a finished result waits while the output word is stalled
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !res_ready_i) |=> state_q == S_DONE)
    else $error("result dropped under output stall");

  // an output word stays up until taken
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ready_i) |=> out_valid_q)
    else $error("output word withdrawn before taken");
endmodule

@@ hw/rtl/frame_interval_timer.sv @@
// Frame interval timer top level: controller, datapath and channel wiring.
//
// Usage: events arrive as words on req_i (req_type, 64-bit timestamp); each
// event yields exactly one result word on res_o (average frame interval,
// latched frame rate, net running time, stopped flag). ticks_per_second is
// written through cfg_we_i/cfg_wdata_i while no event is in flight.
// One event is processed at a time. A frame tick while running passes through
// the execute, check, push and sum-add steps, starts the bit-serial divider
// (window sum / entry count, default depth 64) unless the window is empty and
// waits for it, then forms the net running time and loads the result word.
// Stop, start, reset and a tick while stopped skip the window steps and divider.
// The result sits in an output register, so the next event is accepted while
// a result still waits; if the receiver stalls, the block finishes the next
// event and then holds it until the output register frees.
// Reset clears all counters and timestamps, sets ticks_per_second to
// 10000000 and leaves the window empty; no clearing pass is needed.
module frame_interval_timer #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  fit_stream_if.sink    req_i,
  fit_stream_if.source  res_o
);
  fit_pkg::fit_cmd_t cmd;
  fit_pkg::fit_sts_t sts;
  fit_pkg::req_t     req_word;
  fit_pkg::res_t     res_word;
  logic              req_ready;
  logic              res_valid;

  assign req_word = req_i.data;

  fit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fit_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_word)
  );

  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res_word;
endmodule
